// File: src/cursor_journal_ring_assert.svh
// Assertion macros for the cursor journal ring checker.
// Used by cjr_checker; expects clk and rst_n in scope.
`ifndef CURSOR_JOURNAL_RING_ASSERT_SVH
`define CURSOR_JOURNAL_RING_ASSERT_SVH

// same-cycle implication
`define CJR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CJR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/cjr_pkg.sv
// Shared constants, operation codes and control structs for the journal ring.
// No dependencies.
`timescale 1ns / 1ps

package cjr_pkg;

  localparam int DEPTH  = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = IDX_W + 1;
  localparam int DATA_W = 32;
  localparam int CUR_W  = 32;
  localparam int CAP_W  = 6;
  localparam int KIND_W = 2;
  localparam int CFG_DW = 32;
  localparam int CFG_AW = 2;

  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  localparam logic [CFG_AW-1:0] REG_CAPACITY = 2'd0;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

  typedef struct packed {
    logic take;
    logic prep;
    logic commit;
    logic stat;
    logic cmp;
    logic size;
    logic count;
    logic first;
    logic emit;
    logic one;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              n_zero;
    logic              out_free;
    logic              final_entry;
  } sts_t;

endpackage

// File: src/cjr_ctrl.sv
// Sequencer for the journal ring: steps each item through its phases.
// Depends on cjr_pkg; drives cjr_datapath through cmd_t.
`timescale 1ns / 1ps

module cjr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  cjr_pkg::sts_t sts,
  output cjr_pkg::cmd_t cmd
);
  import cjr_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_PREP   = 10'b0000000010,
    S_COMMIT = 10'b0000000100,
    S_STAT   = 10'b0000001000,
    S_CMP    = 10'b0000010000,
    S_SIZE   = 10'b0000100000,
    S_COUNT  = 10'b0001000000,
    S_READ   = 10'b0010000000,
    S_EMIT   = 10'b0100000000,
    S_ONE    = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_PREP;
      S_PREP:   state_nxt = (sts.kind == KIND_APPEND) ? S_COMMIT : S_STAT;
      S_COMMIT: state_nxt = S_STAT;
      S_STAT:   state_nxt = (sts.kind == KIND_READ) ? S_CMP : S_ONE;
      S_CMP:    state_nxt = S_SIZE;
      S_SIZE:   state_nxt = S_COUNT;
      S_COUNT:  state_nxt = sts.n_zero ? S_ONE : S_READ;
      S_READ:   state_nxt = S_EMIT;
      S_EMIT:   if (sts.out_free && sts.final_entry) state_nxt = S_IDLE;
      S_ONE:    if (sts.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall   = (state_r != S_IDLE);
  assign cmd.take   = (state_r == S_IDLE) && in_valid;
  assign cmd.prep   = (state_r == S_PREP);
  assign cmd.commit = (state_r == S_COMMIT);
  assign cmd.stat   = (state_r == S_STAT);
  assign cmd.cmp    = (state_r == S_CMP);
  assign cmd.size   = (state_r == S_SIZE);
  assign cmd.count  = (state_r == S_COUNT);
  assign cmd.first  = (state_r == S_READ);
  assign cmd.emit   = (state_r == S_EMIT);
  assign cmd.one    = (state_r == S_ONE);

endmodule

// File: src/cjr_datapath.sv
// Journal ring datapath: entry memory, ring pointers, cursor arithmetic,
// capacity register and the result register. Depends on cjr_pkg.
`timescale 1ns / 1ps

module cjr_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cjr_pkg::cmd_t                cmd,
  output cjr_pkg::sts_t                sts,
  input  logic [cjr_pkg::KIND_W-1:0]   in_kind,
  input  logic [cjr_pkg::DATA_W-1:0]   in_payload,
  input  logic [cjr_pkg::CUR_W-1:0]    in_after_cursor,
  input  logic [cjr_pkg::CAP_W-1:0]    in_read_limit,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cjr_pkg::CFG_AW-1:0]   paddr,
  input  logic [cjr_pkg::CFG_DW-1:0]   pwdata,
  output logic [cjr_pkg::CFG_DW-1:0]   prdata,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_accepted,
  output logic                         out_has_entry,
  output logic [cjr_pkg::CUR_W-1:0]    out_entry_cursor,
  output logic [cjr_pkg::DATA_W-1:0]   out_entry_data,
  output logic [cjr_pkg::CUR_W-1:0]    out_oldest_cursor,
  output logic [cjr_pkg::CUR_W-1:0]    out_newest_cursor,
  output logic                         out_cursor_evicted,
  output logic [cjr_pkg::CUR_W-1:0]    out_resume_cursor,
  output logic                         out_last
);
  import cjr_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  logic [CAP_W-1:0]  cap_r;
  logic [IDX_W-1:0]  head_r;
  logic [CNT_W-1:0]  count_r;
  logic [CUR_W-1:0]  cursor_r;

  logic [KIND_W-1:0] kind_r;
  logic [DATA_W-1:0] payload_r;
  logic [CUR_W-1:0]  after_r;
  logic [CAP_W-1:0]  limit_r;

  logic              ok_r;
  logic [CNT_W-1:0]  drop_r;
  logic [CUR_W-1:0]  oldest_r;
  logic [CUR_W-1:0]  newest_r;
  logic [CUR_W:0]    after1_r;
  logic [CAP_W-1:0]  bound_r;
  logic [CUR_W-1:0]  start_r;
  logic              ev_r;
  logic              match_r;
  logic [CUR_W-1:0]  rem_r;
  logic [IDX_W-1:0]  skip_r;
  logic [CAP_W-1:0]  k_r;
  logic [IDX_W-1:0]  ptr_r;
  logic [CUR_W-1:0]  cur_r;
  logic [CUR_W-1:0]  resume_r;

  logic              out_valid_r;
  logic              acc_r, has_r, ev_o_r, last_r;
  logic [CUR_W-1:0]  ecur_r, old_o_r, new_o_r, res_o_r;
  logic [DATA_W-1:0] edata_r;

  logic [CAP_W-1:0]  cap_eff;
  logic [CAP_W-1:0]  n_val;
  logic              out_free;
  logic              load;
  logic              rd_en;
  logic              cfg_we;

  assign cap_eff  = (cap_r > CAP_W'(DEPTH)) ? CAP_W'(DEPTH) : cap_r;
  assign out_free = !out_valid_r || !out_stall;
  assign load     = (cmd.one || cmd.emit) && out_free;
  assign rd_en    = cmd.first || (cmd.emit && out_free && (k_r != CAP_W'(1)));
  assign cfg_we   = psel && penable && pwrite && (paddr == REG_CAPACITY);

  assign n_val = !match_r ? '0 :
                 (rem_r < CUR_W'(bound_r)) ? (rem_r[CAP_W-1:0] + CAP_W'(1)) : bound_r;

  assign sts.kind        = kind_r;
  assign sts.n_zero      = (n_val == '0);
  assign sts.out_free    = out_free;
  assign sts.final_entry = (k_r == CAP_W'(1));

  assign prdata = {{(CFG_DW-CAP_W){1'b0}}, cap_r};

  // entry memory
  always_ff @(posedge clk) begin
    if (cmd.commit && ok_r) begin
      mem[head_r + count_r[IDX_W-1:0]] <= payload_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[ptr_r];
    end
  end

  // capacity register and ring state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= CAP_RESET;
      head_r   <= '0;
      count_r  <= '0;
      cursor_r <= CUR_W'(1);
    end else begin
      if (cfg_we) begin
        cap_r <= pwdata[CAP_W-1:0];
      end
      if (cmd.prep && (kind_r == KIND_CLEAR)) begin
        head_r   <= '0;
        count_r  <= '0;
        cursor_r <= CUR_W'(1);
      end else if (cmd.commit && ok_r) begin
        head_r   <= head_r + drop_r[IDX_W-1:0];
        count_r  <= count_r - drop_r + CNT_W'(1);
        cursor_r <= cursor_r + CUR_W'(1);
      end
    end
  end

  // item and working registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      kind_r    <= in_kind;
      payload_r <= in_payload;
      after_r   <= in_after_cursor;
      limit_r   <= in_read_limit;
    end
    if (cmd.prep) begin
      ok_r   <= (cap_eff != '0) && (cursor_r != '1);
      drop_r <= (count_r >= CNT_W'(cap_eff)) ?
                (count_r - CNT_W'(cap_eff) + CNT_W'(1)) : '0;
    end
    if (cmd.stat) begin
      oldest_r <= (count_r == '0) ? '0 : (cursor_r - CUR_W'(count_r));
      newest_r <= (count_r == '0) ? '0 : (cursor_r - CUR_W'(1));
      after1_r <= {1'b0, after_r} + (CUR_W+1)'(1);
      bound_r  <= (limit_r < cap_eff) ? limit_r : cap_eff;
    end
    if (cmd.cmp) begin
      start_r <= (after1_r > {1'b0, oldest_r}) ? after1_r[CUR_W-1:0] : oldest_r;
      ev_r    <= (count_r != '0) && (after_r != '0) && (after1_r < {1'b0, oldest_r});
      match_r <= (count_r != '0) && (after_r < newest_r);
    end
    if (cmd.size) begin
      rem_r  <= newest_r - start_r;
      skip_r <= start_r[IDX_W-1:0] - oldest_r[IDX_W-1:0];
    end
    if (cmd.count) begin
      k_r   <= n_val;
      ptr_r <= head_r + skip_r;
    end
    if (cmd.first) begin
      ptr_r    <= ptr_r + IDX_W'(1);
      cur_r    <= start_r;
      resume_r <= start_r + CUR_W'(k_r) - CUR_W'(1);
    end
    if (cmd.emit && out_free) begin
      ptr_r <= ptr_r + IDX_W'(1);
      cur_r <= cur_r + CUR_W'(1);
      k_r   <= k_r - CAP_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      old_o_r <= oldest_r;
      new_o_r <= newest_r;
      if (cmd.emit) begin
        acc_r   <= 1'b1;
        has_r   <= 1'b1;
        ecur_r  <= cur_r;
        edata_r <= rd_data_r;
        ev_o_r  <= ev_r;
        res_o_r <= resume_r;
        last_r  <= (k_r == CAP_W'(1));
      end else begin
        has_r   <= 1'b0;
        ecur_r  <= '0;
        edata_r <= '0;
        last_r  <= 1'b1;
        case (kind_r)
          KIND_APPEND: begin
            acc_r   <= ok_r;
            ev_o_r  <= 1'b0;
            res_o_r <= '0;
          end
          KIND_READ: begin
            acc_r   <= 1'b1;
            ev_o_r  <= ev_r;
            res_o_r <= after_r;
          end
          KIND_CLEAR: begin
            acc_r   <= 1'b1;
            ev_o_r  <= 1'b0;
            res_o_r <= '0;
          end
          default: begin
            acc_r   <= 1'b0;
            ev_o_r  <= 1'b0;
            res_o_r <= '0;
          end
        endcase
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_accepted       = acc_r;
  assign out_has_entry      = has_r;
  assign out_entry_cursor   = ecur_r;
  assign out_entry_data     = edata_r;
  assign out_oldest_cursor  = old_o_r;
  assign out_newest_cursor  = new_o_r;
  assign out_cursor_evicted = ev_o_r;
  assign out_resume_cursor  = res_o_r;
  assign out_last           = last_r;

endmodule

// File: src/cursor_journal_ring.sv
// Top level of the cursor journal ring: sequencer plus datapath.
// Depends on cjr_pkg, cjr_ctrl, cjr_datapath.
//
//   port group  | handshake              | moves
//   in_*        | in_valid / in_stall    | one item: kind, payload, cursor, limit
//   out_*       | out_valid / out_stall  | one result item per entry or per item
//   psel..      | APB setup + access     | capacity register at byte address 0
//
// Phases: append runs prep, commit, stat, result; clear and unused kind skip
// commit; read adds cmp, size, count, then n entries (one result when none)
// via the registered memory read port, one entry a cycle unless out_stall.
// Reset is synchronous; no memory clearing pass, entries are read only once
// written. A stalled result holds; a new item is taken while it waits.
`timescale 1ns / 1ps

module cursor_journal_ring (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [cjr_pkg::KIND_W-1:0]   in_kind,
  input  logic [cjr_pkg::DATA_W-1:0]   in_payload,
  input  logic [cjr_pkg::CUR_W-1:0]    in_after_cursor,
  input  logic [cjr_pkg::CAP_W-1:0]    in_read_limit,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_accepted,
  output logic                         out_has_entry,
  output logic [cjr_pkg::CUR_W-1:0]    out_entry_cursor,
  output logic [cjr_pkg::DATA_W-1:0]   out_entry_data,
  output logic [cjr_pkg::CUR_W-1:0]    out_oldest_cursor,
  output logic [cjr_pkg::CUR_W-1:0]    out_newest_cursor,
  output logic                         out_cursor_evicted,
  output logic [cjr_pkg::CUR_W-1:0]    out_resume_cursor,
  output logic                         out_last,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cjr_pkg::CFG_AW-1:0]   paddr,
  input  logic [cjr_pkg::CFG_DW-1:0]   pwdata,
  output logic [cjr_pkg::CFG_DW-1:0]   prdata,
  output logic                         pready
);
  import cjr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;

  cjr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  cjr_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_kind            (in_kind),
    .in_payload         (in_payload),
    .in_after_cursor    (in_after_cursor),
    .in_read_limit      (in_read_limit),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_accepted       (out_accepted),
    .out_has_entry      (out_has_entry),
    .out_entry_cursor   (out_entry_cursor),
    .out_entry_data     (out_entry_data),
    .out_oldest_cursor  (out_oldest_cursor),
    .out_newest_cursor  (out_newest_cursor),
    .out_cursor_evicted (out_cursor_evicted),
    .out_resume_cursor  (out_resume_cursor),
    .out_last           (out_last)
  );

endmodule

// File: src/cjr_checker.sv
// Port-level checks for cursor_journal_ring, bound to the top level.
// Depends on cjr_pkg and cursor_journal_ring_assert.svh.
`timescale 1ns / 1ps
`include "cursor_journal_ring_assert.svh"

module cjr_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_accepted,
  input logic                         out_has_entry,
  input logic [cjr_pkg::CUR_W-1:0]    out_entry_cursor,
  input logic [cjr_pkg::CUR_W-1:0]    out_oldest_cursor,
  input logic [cjr_pkg::CUR_W-1:0]    out_newest_cursor,
  input logic [cjr_pkg::CUR_W-1:0]    out_resume_cursor,
  input logic                         out_last
);
  import cjr_pkg::*;

  logic                   out_wait;
  logic [2*CUR_W+2:0]     out_view;
  logic                   entry_in_range;

  assign out_wait = out_valid && out_stall;
  assign out_view = {out_accepted, out_has_entry, out_last, out_entry_cursor,
                     out_resume_cursor};
  assign entry_in_range = (out_entry_cursor != '0) &&
                          (out_entry_cursor >= out_oldest_cursor) &&
                          (out_entry_cursor <= out_newest_cursor) &&
                          (out_resume_cursor >= out_entry_cursor);

  `CJR_ASSERT_NEXT(a_out_hold, out_wait, out_valid && $stable(out_view), "held result changed")
  `CJR_ASSERT_NOW(a_entry_acc, out_valid && out_has_entry, out_accepted, "entry not accepted")
  `CJR_ASSERT_NOW(a_empty_last, out_valid && !out_has_entry, out_last, "empty result not final")
  `CJR_ASSERT_NOW(a_entry_range, out_valid && out_has_entry, entry_in_range, "entry out of range")

endmodule

bind cursor_journal_ring cjr_checker u_cjr_checker (.*);
